### rtl/core/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the LRU record cache tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

  localparam int CACHE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int SLOT_W      = $clog2(CACHE_DEPTH);
  localparam int RANK_W      = $clog2(CACHE_DEPTH);
  localparam int IN_KEY_W    = 32;
  localparam int OUT_SLOT_W  = 4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [RANK_W-1:0]      rank_t;
  typedef logic [CACHE_DEPTH-1:0] vec_t;

  localparam rank_t MAX_RANK = RANK_W'(CACHE_DEPTH - 1);

  typedef struct packed {
    logic  hit;
    vec_t  match_vec;
    slot_t found;
    rank_t found_rank;
    logic  free_avail;
    slot_t free_slot;
    slot_t victim;
    key_t  victim_key;
  } lookup_res_t;

endpackage

`default_nettype wire

### rtl/core/lrc_lookup.sv
// ----------------------------------------------------------------------------
// lrc_lookup
// Parallel tag compare, lowest free slot search and LRU victim select.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_lookup
  import lrc_pkg::*;
(
  input  var key_t        key,
  input  var key_t        tag_store_r [CACHE_DEPTH],
  input  var vec_t        entry_valid_r,
  input  var rank_t       age_rank_r  [CACHE_DEPTH],
  output lookup_res_t     res
);

  always_comb begin
    res = '0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      res.match_vec[i] = entry_valid_r[i] && (tag_store_r[i] == key);
      if (res.match_vec[i]) begin
        res.hit   = 1'b1;
        res.found = SLOT_W'(i);
      end
      if (!entry_valid_r[i]) begin
        res.free_avail = 1'b1;
        res.free_slot  = SLOT_W'(i);
      end
      if (entry_valid_r[i] && (age_rank_r[i] == MAX_RANK)) begin
        res.victim = SLOT_W'(i);
      end
    end
    res.victim_key = tag_store_r[res.victim];
    res.found_rank = age_rank_r[res.found];
  end

endmodule

`default_nettype wire

### rtl/core/lrc_store.sv
// ----------------------------------------------------------------------------
// lrc_store
// Tag, valid and age rank registers with their per-transfer update.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_store
  import lrc_pkg::*;
(
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        upd,
  input  var logic        opcode,
  input  var key_t        key,
  input  var lookup_res_t res,
  output key_t            tag_store_r   [CACHE_DEPTH],
  output vec_t            entry_valid_r,
  output rank_t           age_rank_r    [CACHE_DEPTH]
);

  vec_t  entry_valid_nxt;
  rank_t age_rank_nxt [CACHE_DEPTH];
  slot_t wr_slot;
  logic  do_fill;

  assign wr_slot = res.free_avail ? res.free_slot : res.victim;
  assign do_fill = upd && (opcode == OP_LOOKUP) && !res.hit;

  function automatic rank_t age_sat(input rank_t r);
    return (r == MAX_RANK) ? r : r + 1'b1;
  endfunction

  always_comb begin
    entry_valid_nxt = entry_valid_r;
    age_rank_nxt    = age_rank_r;
    if (upd) begin
      if (opcode == OP_CLEAR) begin
        entry_valid_nxt = '0;
        for (int i = 0; i < CACHE_DEPTH; i++) age_rank_nxt[i] = '0;
      end else if (res.hit) begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (SLOT_W'(i) == res.found) begin
            age_rank_nxt[i] = '0;
          end else if (entry_valid_r[i] && (age_rank_r[i] < res.found_rank)) begin
            age_rank_nxt[i] = age_sat(age_rank_r[i]);
          end
        end
      end else if (res.free_avail) begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (SLOT_W'(i) == res.free_slot) begin
            age_rank_nxt[i]    = '0;
            entry_valid_nxt[i] = 1'b1;
          end else if (entry_valid_r[i]) begin
            age_rank_nxt[i] = age_sat(age_rank_r[i]);
          end
        end
      end else begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (SLOT_W'(i) == res.victim) begin
            age_rank_nxt[i] = '0;
          end else begin
            age_rank_nxt[i] = age_sat(age_rank_r[i]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      for (int i = 0; i < CACHE_DEPTH; i++) age_rank_r[i] <= '0;
    end else begin
      entry_valid_r <= entry_valid_nxt;
      age_rank_r    <= age_rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_fill) begin
      tag_store_r[wr_slot] <= key;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lru_record_cache_tags_top.sv
// ----------------------------------------------------------------------------
// lru_record_cache_tags_top
// Fully associative 16-entry tag store with least recently used replacement.
//
// The input channel takes an opcode (lookup or clear) and a 32-bit record key.
// Each transfer on it yields exactly one result on the output channel: hit
// flag, slot holding the key, and the evicted key when a full store misses.
// An accepted item sits in an input register, where all 16 tag
// compares, the free slot and victim search and the age rank update run in a
// single pass; its result is loaded into the output register once that
// register is empty or its result is being taken. One item is taken every
// cycle while the output side keeps up. When the receiver stalls, the
// result holds in the output register, one more item may wait in the input
// register, and then in_stall rises. Reset empties both registers, clears
// every valid bit and age rank; no clearing pass is run, so the block takes
// items as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_record_cache_tags_top
  import lrc_pkg::*;
(
  input  var logic                  clk,
  input  var logic                  rst_n,
  input  var logic                  in_valid,
  output logic                      in_stall,
  input  var logic                  in_opcode,
  input  var logic [IN_KEY_W-1:0]   in_record_key,
  output logic                      out_valid,
  input  var logic                  out_stall,
  output logic                      out_hit,
  output logic [OUT_SLOT_W-1:0]     out_slot_index,
  output logic                      out_evicted_valid,
  output logic [IN_KEY_W-1:0]       out_evicted_key
);

  logic        s1_valid_r;
  logic        s1_op_r;
  key_t        s1_key_r;
  logic        s1_go;
  logic        in_take;

  logic                  out_valid_r;
  logic                  hit_r;
  logic [OUT_SLOT_W-1:0] slot_r;
  logic                  ev_valid_r;
  logic [IN_KEY_W-1:0]   ev_key_r;

  logic                  hit_nxt;
  logic [OUT_SLOT_W-1:0] slot_nxt;
  logic                  ev_valid_nxt;
  logic [IN_KEY_W-1:0]   ev_key_nxt;

  key_t        tag_store_r [CACHE_DEPTH];
  vec_t        entry_valid_r;
  rank_t       age_rank_r  [CACHE_DEPTH];
  lookup_res_t res;

  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  lrc_lookup u_lookup (
    .key           (s1_key_r),
    .tag_store_r   (tag_store_r),
    .entry_valid_r (entry_valid_r),
    .age_rank_r    (age_rank_r),
    .res           (res)
  );

  lrc_store u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (s1_go),
    .opcode        (s1_op_r),
    .key           (s1_key_r),
    .res           (res),
    .tag_store_r   (tag_store_r),
    .entry_valid_r (entry_valid_r),
    .age_rank_r    (age_rank_r)
  );

  always_comb begin
    hit_nxt      = 1'b0;
    slot_nxt     = '0;
    ev_valid_nxt = 1'b0;
    ev_key_nxt   = '0;
    if (s1_op_r == OP_LOOKUP) begin
      if (res.hit) begin
        hit_nxt  = 1'b1;
        slot_nxt = OUT_SLOT_W'(res.found);
      end else if (res.free_avail) begin
        slot_nxt = OUT_SLOT_W'(res.free_slot);
      end else begin
        slot_nxt     = OUT_SLOT_W'(res.victim);
        ev_valid_nxt = 1'b1;
        ev_key_nxt   = IN_KEY_W'(res.victim_key);
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= in_opcode;
      s1_key_r <= KEY_BITS'(in_record_key);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      hit_r      <= hit_nxt;
      slot_r     <= slot_nxt;
      ev_valid_r <= ev_valid_nxt;
      ev_key_r   <= ev_key_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_slot_index    = slot_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_key   = ev_key_r;

  a_one_match : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(res.match_vec))
    else $error("more than one valid entry matches the key");

  a_hit_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> !ev_valid_r && (ev_key_r == '0))
    else $error("hit reported together with an eviction");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_key_r) && $stable(s1_op_r))
    else $error("input register lost a waiting item");

  a_evict_full : assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_op_r == OP_LOOKUP) && !res.hit && !res.free_avail |->
      entry_valid_r[res.victim] && (age_rank_r[res.victim] == MAX_RANK))
    else $error("eviction chose an entry that is not least recently used");

endmodule

`default_nettype wire
